### rtl/core/seven_segment_number_formatter_assert.svh
// Assertion macros used by the seven-segment number formatter top level.
`ifndef SEVEN_SEGMENT_NUMBER_FORMATTER_ASSERT_SVH
`define SEVEN_SEGMENT_NUMBER_FORMATTER_ASSERT_SVH

`ifndef ASSERT_OFF

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define ASSERT_IMPL(label, clk, rst, ante, cons)
`define ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/core/ssnf_pkg.sv
// Types, constants and glyph functions of the seven-segment number formatter.
`default_nettype none

package ssnf_pkg;

  // Display geometry.
  localparam int MAX_DIGITS  = 8;
  localparam int DIGIT_LIMIT = (MAX_DIGITS < 8) ? MAX_DIGITS : 8;
  localparam int ND_W        = 4;
  localparam logic [ND_W-1:0] NUM_DIGITS_RESET = 4'd4;

  // Binary to decimal conversion: ten digits, four source bits per cycle.
  localparam int VALUE_W       = 32;
  localparam int BCD_DIGITS    = 10;
  localparam int BCD_W         = 4 * BCD_DIGITS;
  localparam int BITS_PER_STEP = 4;
  localparam int CONV_STEPS    = VALUE_W / BITS_PER_STEP;
  localparam int CONV_CNT_W    = $clog2(CONV_STEPS + 1);

  // Segment patterns, bit 7 DP down to bit 0 A.
  localparam logic [7:0] GLYPH_ZERO  = 8'b00111111;
  localparam logic [7:0] GLYPH_MINUS = 8'b01000000;
  localparam logic [7:0] GLYPH_UNDER = 8'b00001000;
  localparam logic [7:0] GLYPH_H     = 8'b01110110;
  localparam logic [7:0] GLYPH_R     = 8'b01010000;
  localparam logic [7:0] SEG_POINT   = 8'h80;

  typedef enum logic [2:0] {
    CMD_DECIMAL = 3'd0,
    CMD_HEX     = 3'd1,
    CMD_CHAR    = 3'd2,
    CMD_RAW     = 3'd3,
    CMD_SPIN    = 3'd4,
    CMD_CLEAR   = 3'd5
  } cmd_t;

  typedef enum logic [2:0] {
    JOB_DEC,
    JOB_DASH,
    JOB_HEX,
    JOB_SINGLE,
    JOB_CLEAR
  } job_kind_t;

  typedef enum logic {
    FR_IDLE,
    FR_CONV
  } front_state_t;

  // One classified command as it travels from the front to the back.
  typedef struct packed {
    job_kind_t        kind;
    logic [ND_W-1:0]  nd;     // digit count in use
    logic [3:0]       count;  // significant decimal digits or hex nibbles to show
    logic             neg;
    logic             lz;
    logic [2:0]       pos;
    logic [BCD_W-1:0] data;   // BCD digits, hex value or single pattern
  } job_t;

  // One result as driven onto the output ports.
  typedef struct packed {
    logic       valid;
    logic [2:0] pos;
    logic [7:0] seg;
    logic       blank;
    logic       fits;
    logic       last;
  } result_t;

  function automatic logic [7:0] hex_glyph(input logic [3:0] n);
    logic [7:0] g;
    case (n)
      4'h0:    g = GLYPH_ZERO;
      4'h1:    g = 8'h06;
      4'h2:    g = 8'h5B;
      4'h3:    g = 8'h4F;
      4'h4:    g = 8'h66;
      4'h5:    g = 8'h6D;
      4'h6:    g = 8'h7D;
      4'h7:    g = 8'h07;
      4'h8:    g = 8'h7F;
      4'h9:    g = 8'h6F;
      4'hA:    g = 8'h77;
      4'hB:    g = 8'h7C;
      4'hC:    g = 8'h39;
      4'hD:    g = 8'h5E;
      4'hE:    g = 8'h79;
      4'hF:    g = 8'h71;
      default: g = 8'h00;
    endcase
    return g;
  endfunction

  // ASCII to glyph; characters without a glyph come out dark.
  function automatic logic [7:0] char_glyph(input logic [7:0] c);
    logic [7:0] g;
    g = 8'h00;
    if (c >= 8'h30 && c <= 8'h39) begin
      g = hex_glyph(4'(c - 8'h30));
    end else if (c >= 8'h41 && c <= 8'h46) begin
      g = hex_glyph(4'(c - 8'h37));
    end else if (c >= 8'h61 && c <= 8'h66) begin
      g = hex_glyph(4'(c - 8'h57));
    end else begin
      case (c)
        8'h48, 8'h68: g = GLYPH_H;
        8'h4A, 8'h6A: g = 8'h1E;
        8'h4C, 8'h6C: g = 8'h38;
        8'h4E, 8'h6E: g = 8'h54;
        8'h4F, 8'h6F: g = 8'h5C;
        8'h50, 8'h70: g = 8'h73;
        8'h52, 8'h72: g = GLYPH_R;
        8'h55, 8'h75: g = 8'h3E;
        8'h59, 8'h79: g = 8'h6E;
        8'h2D:        g = GLYPH_MINUS;
        8'h5F:        g = GLYPH_UNDER;
        default:      g = 8'h00;
      endcase
    end
    return g;
  endfunction

  // One outer segment lit, chosen by the step modulo six. The quotient comes
  // from a multiply by 171/1024, which is exact for all 8-bit steps.
  function automatic logic [7:0] spin_glyph(input logic [7:0] s);
    logic [15:0] prod;
    logic [5:0]  q;
    logic [7:0]  r;
    prod = 16'(s) * 16'd171;
    q    = prod[15:10];
    r    = s - 8'(q) * 8'd6;
    return 8'd1 << r[2:0];
  endfunction

endpackage

`default_nettype wire

### rtl/core/seven_segment_number_formatter.sv
// Top level of the seven-segment number formatter.
`default_nettype none
//
// A command is transferred on a rising edge with start high and busy low. It
// becomes one segment pattern per digit touched, each shown on the result
// ports for exactly one cycle with result_valid high; last marks the final
// transfer of a command. The receiver cannot stall, so patterns leave at one
// per cycle once a command reaches the digit emitter.
// A hex, character, raw, spin or clear command goes straight to the queue;
// a decimal command first passes through the binary-to-decimal unit (four
// bits per cycle) and is queued once the conversion is done and the queue
// has room. A command occupies the emitter while it writes its digits (one
// for single-digit commands, up to eight otherwise); a two-entry queue lets
// the front take further commands meanwhile. busy stays high through a
// decimal conversion and whenever the queue is full.
// num_digits is written over the cfg channel (always ready); it must be
// written only while idle, which the block itself does not enforce; it
// resets to four. Reset empties the queue and drops any result in flight.
//
`include "seven_segment_number_formatter_assert.svh"

module seven_segment_number_formatter
  import ssnf_pkg::*;
(
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            cfg_valid,
  output logic                 cfg_ready,
  input  wire logic [ND_W-1:0] cfg_data,
  input  wire logic            start,
  output logic                 busy,
  input  wire logic [2:0]      command,
  input  wire logic [31:0]     value,
  input  wire logic            leading_zeros,
  input  wire logic [3:0]      digits_wanted,
  input  wire logic [2:0]      position,
  input  wire logic [7:0]      char_code,
  input  wire logic [7:0]      segment_mask,
  input  wire logic            show_dp,
  input  wire logic [7:0]      spin_step,
  output logic                 result_valid,
  output logic [2:0]           digit_position,
  output logic [7:0]           segments,
  output logic                 blank,
  output logic                 fits,
  output logic                 last
);

  logic [ND_W-1:0] num_digits;
  logic [ND_W-1:0] nd_eff;
  logic            q_full;
  logic            q_valid;
  logic            push;
  logic            pop;
  job_t            push_job;
  job_t            head;
  result_t         res;

  // Digit count register.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      num_digits <= NUM_DIGITS_RESET;
    end else if (cfg_valid && cfg_ready) begin
      num_digits <= cfg_data;
    end
  end

  assign nd_eff = (num_digits > ND_W'(DIGIT_LIMIT)) ? ND_W'(DIGIT_LIMIT) : num_digits;

  ssnf_front u_front (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .command       (command),
    .value         (value),
    .leading_zeros (leading_zeros),
    .digits_wanted (digits_wanted),
    .position      (position),
    .char_code     (char_code),
    .segment_mask  (segment_mask),
    .show_dp       (show_dp),
    .spin_step     (spin_step),
    .nd            (nd_eff),
    .q_full        (q_full),
    .push          (push),
    .push_job      (push_job)
  );

  ssnf_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .q_full   (q_full),
    .q_valid  (q_valid),
    .head     (head)
  );

  ssnf_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .q_job   (head),
    .pop     (pop),
    .res     (res)
  );

  // Result ports.
  assign result_valid   = res.valid;
  assign digit_position = res.pos;
  assign segments       = res.seg;
  assign blank          = res.blank;
  assign fits           = res.fits;
  assign last           = res.last;

  // A blanked digit carries no segments.
  `ASSERT_IMPL(a_blank_dark, clk, rst, result_valid && blank, segments == 8'h00)
  // Overflow results are always drawn dashes.
  `ASSERT_IMPL(a_overflow_dash, clk, rst, result_valid && !fits, segments == GLYPH_MINUS && !blank)
  // A decimal transfer holds the front busy while it converts.
  `ASSERT_NEXT(a_conv_busy, clk, rst, start && !busy && command == CMD_DECIMAL && nd_eff != 4'd0, busy)

endmodule

`default_nettype wire

### rtl/core/ssnf_front.sv
// Front end: accepts commands, converts decimal values and classifies jobs.
`default_nettype none

module ssnf_front
  import ssnf_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  output logic                  busy,
  input  wire logic [2:0]       command,
  input  wire logic [31:0]      value,
  input  wire logic             leading_zeros,
  input  wire logic [3:0]       digits_wanted,
  input  wire logic [2:0]       position,
  input  wire logic [7:0]       char_code,
  input  wire logic [7:0]       segment_mask,
  input  wire logic             show_dp,
  input  wire logic [7:0]       spin_step,
  input  wire logic [ND_W-1:0]  nd,
  input  wire logic             q_full,
  output logic                  push,
  output job_t                  push_job
);

  front_state_t            state;
  front_state_t            state_next;
  logic [CONV_CNT_W-1:0]   conv_cnt;
  logic [VALUE_W-1:0]      mag;
  logic [BCD_W-1:0]        bcd;
  logic [ND_W-1:0]         nd_r;
  logic                    neg_r;
  logic                    lz_r;

  cmd_t                    cmd;
  logic                    accept;
  logic                    conv_done;
  logic                    start_conv;
  job_t                    imm_job;
  logic                    imm_push;
  job_t                    conv_job;
  logic [3:0]              hex_n;
  logic                    pos_ok;
  logic [BCD_W-1:0]        bcd_w;
  logic [VALUE_W-1:0]      mag_w;
  logic [3:0]              dc;
  logic                    overflow;

  assign cmd        = cmd_t'(command);
  assign accept     = start && !busy;
  assign conv_done  = (conv_cnt == CONV_CNT_W'(CONV_STEPS));
  assign start_conv = accept && (cmd == CMD_DECIMAL) && (nd != '0);
  assign pos_ok     = ({1'b0, position} < nd);
  assign hex_n      = ((digits_wanted == 4'd0) || (digits_wanted > nd)) ? nd : digits_wanted;

  // Classification of every command that needs no conversion.
  always_comb begin
    imm_job      = '0;
    imm_push     = 1'b0;
    imm_job.kind = JOB_CLEAR;
    imm_job.nd   = nd;
    imm_job.lz   = leading_zeros;
    imm_job.pos  = position;
    case (cmd)
      CMD_HEX: begin
        imm_job.kind  = JOB_HEX;
        imm_job.count = hex_n;
        imm_job.data  = {{(BCD_W - VALUE_W){1'b0}}, value};
        imm_push      = (nd != '0);
      end
      CMD_CHAR: begin
        imm_job.kind      = JOB_SINGLE;
        imm_job.data[7:0] = char_glyph(char_code) | (show_dp ? SEG_POINT : 8'h00);
        imm_push          = pos_ok;
      end
      CMD_RAW: begin
        imm_job.kind      = JOB_SINGLE;
        imm_job.data[7:0] = segment_mask;
        imm_push          = pos_ok;
      end
      CMD_SPIN: begin
        imm_job.kind      = JOB_SINGLE;
        imm_job.data[7:0] = spin_glyph(spin_step);
        imm_push          = pos_ok;
      end
      CMD_CLEAR: begin
        imm_job.kind = JOB_CLEAR;
        imm_push     = (nd != '0);
      end
      default: begin
        imm_push = 1'b0;
      end
    endcase
  end

  // Four double-dabble steps per cycle.
  always_comb begin
    bcd_w = bcd;
    mag_w = mag;
    for (int s = 0; s < BITS_PER_STEP; s++) begin
      for (int d = 0; d < BCD_DIGITS; d++) begin
        if (bcd_w[d*4 +: 4] >= 4'd5) begin
          bcd_w[d*4 +: 4] = bcd_w[d*4 +: 4] + 4'd3;
        end
      end
      {bcd_w, mag_w} = {bcd_w[BCD_W-2:0], mag_w, 1'b0};
    end
  end

  // Significant digit count and fit check of the converted number.
  always_comb begin
    dc = 4'd1;
    for (int d = 1; d < BCD_DIGITS; d++) begin
      if (bcd[d*4 +: 4] != 4'd0) begin
        dc = 4'(d + 1);
      end
    end
    overflow       = (({1'b0, dc} + 5'(neg_r)) > {1'b0, nd_r});
    conv_job       = '0;
    conv_job.kind  = overflow ? JOB_DASH : JOB_DEC;
    conv_job.nd    = nd_r;
    conv_job.count = dc;
    conv_job.neg   = neg_r;
    conv_job.lz    = lz_r;
    conv_job.data  = bcd;
  end

  // Next state.
  always_comb begin
    state_next = state;
    case (state)
      FR_IDLE: begin
        if (start_conv) begin
          state_next = FR_CONV;
        end
      end
      FR_CONV: begin
        if (conv_done && !q_full) begin
          state_next = FR_IDLE;
        end
      end
      default: begin
        state_next = FR_IDLE;
      end
    endcase
  end

  // Outputs.
  always_comb begin
    busy     = 1'b1;
    push     = 1'b0;
    push_job = imm_job;
    case (state)
      FR_IDLE: begin
        busy     = q_full;
        push     = accept && imm_push;
        push_job = imm_job;
      end
      FR_CONV: begin
        busy     = 1'b1;
        push     = conv_done && !q_full;
        push_job = conv_job;
      end
      default: begin
        busy = 1'b1;
      end
    endcase
  end

  // Control state.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= FR_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Conversion datapath.
  always_ff @(posedge clk) begin
    if (start_conv) begin
      mag      <= value[31] ? (32'd0 - value) : value;
      bcd      <= '0;
      conv_cnt <= '0;
      nd_r     <= nd;
      neg_r    <= value[31];
      lz_r     <= leading_zeros;
    end else if (state == FR_CONV && !conv_done) begin
      mag      <= mag_w;
      bcd      <= bcd_w;
      conv_cnt <= conv_cnt + CONV_CNT_W'(1);
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssnf_queue.sv
// Two-entry job queue between the front end and the digit emitter.
`default_nettype none

module ssnf_queue
  import ssnf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic push,
  input  wire job_t push_job,
  input  wire logic pop,
  output logic      q_full,
  output logic      q_valid,
  output job_t      head
);

  job_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] fill;

  assign q_full  = (fill == 2'd2);
  assign q_valid = (fill != 2'd0);
  assign head    = entry[rd_ptr];

  // Pointers and fill level.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= !wr_ptr;
      end
      if (pop) begin
        rd_ptr <= !rd_ptr;
      end
      fill <= fill + {1'b0, push} - {1'b0, pop};
    end
  end

  // Storage.
  always_ff @(posedge clk) begin
    if (push) begin
      entry[wr_ptr] <= push_job;
    end
  end

endmodule

`default_nettype wire

### rtl/core/ssnf_back.sv
// Back end: walks the digits of one job and emits one pattern per cycle.
`default_nettype none

module ssnf_back
  import ssnf_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst,
  input  wire logic q_valid,
  input  wire job_t q_job,
  output logic      pop,
  output result_t   res
);

  logic       active;
  job_t       cur;
  logic [2:0] p;

  logic       fin;
  logic [2:0] dpos;
  logic [3:0] dig;
  logic       below;
  result_t    res_next;

  assign dpos  = 3'(cur.nd - 4'd1 - {1'b0, p});
  assign dig   = cur.data[{p, 2'b00} +: 4];
  assign below = ({1'b0, p} < cur.count);
  assign fin   = active && ((cur.kind == JOB_SINGLE) || ({1'b0, p} == cur.nd - 4'd1));
  assign pop   = q_valid && (!active || fin);

  // Pattern for the current digit.
  always_comb begin
    res_next       = '0;
    res_next.valid = active;
    res_next.fits  = 1'b1;
    res_next.last  = fin;
    case (cur.kind)
      JOB_DEC: begin
        res_next.pos = dpos;
        if (below) begin
          res_next.seg = hex_glyph(dig);
        end else if (cur.neg && (cur.lz ? (dpos == 3'd0) : ({1'b0, p} == cur.count))) begin
          res_next.seg = GLYPH_MINUS;
        end else if (cur.lz) begin
          res_next.seg = GLYPH_ZERO;
        end else begin
          res_next.blank = 1'b1;
        end
      end
      JOB_DASH: begin
        res_next.pos  = p;
        res_next.seg  = GLYPH_MINUS;
        res_next.fits = 1'b0;
      end
      JOB_HEX: begin
        res_next.pos = dpos;
        if (below) begin
          res_next.seg = hex_glyph(dig);
        end else begin
          res_next.blank = 1'b1;
        end
      end
      JOB_SINGLE: begin
        res_next.pos = cur.pos;
        res_next.seg = cur.data[7:0];
      end
      JOB_CLEAR: begin
        res_next.pos   = p;
        res_next.blank = 1'b1;
      end
      default: begin
        res_next.blank = 1'b1;
      end
    endcase
  end

  // Job sequencing.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
    end else if (pop) begin
      active <= 1'b1;
    end else if (fin) begin
      active <= 1'b0;
    end
  end

  // Current job and digit counter.
  always_ff @(posedge clk) begin
    if (pop) begin
      cur <= q_job;
      p   <= 3'd0;
    end else if (active) begin
      p <= p + 3'd1;
    end
  end

  // Output register; only the strobe is cleared by reset.
  always_ff @(posedge clk) begin
    if (rst) begin
      res.valid <= 1'b0;
    end else begin
      res <= res_next;
    end
  end

endmodule

`default_nettype wire
